// File: src/qeda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qeda_pkg: shared types and constants for the edge divergence accumulator
// Command codes, sequencer states, multiplier unit control and the Hamilton
// product term table.
// ----------------------------------------------------------------------------
package qeda_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int FRAC_BITS_DEF    = 16;

	// divide-by-six unit: dividend width, quotient bits per step, steps
	localparam int          DIV_W     = 35;
	localparam int          DIV_R     = 7;
	localparam int          DIV_STEPS = DIV_W / DIV_R;
	localparam int          DIV_CW    = 3;
	localparam logic [3:0]  DIV_K     = 4'd6;
	// ceil(2^12 / 6), exact for any partial dividend below 2048
	localparam logic [9:0]  DIV_RECIP = 10'd683;
	localparam int          DIV_RSH   = 12;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_EDGE = 2'd1,
		CMD_READ = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_t;

	// the six quaternion products of one edge, in issue order
	typedef enum logic [2:0] {
		PROD_T1, PROD_A, PROD_B, PROD_T2, PROD_C, PROD_D
	} prod_t;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RDB, ST_CAPB, ST_MUL, ST_DRAIN, ST_DIVGO, ST_DIV,
		ST_DMUL, ST_DRAIN2, ST_ACC_RA, ST_ACC_WA, ST_ACC_RB, ST_ACC_WB, ST_RD_DATA
	} state_t;

	typedef struct packed {
		logic       valid;
		logic       first;
		logic       last;
		logic       neg;
		logic       dmode;
		logic [1:0] comp;
	} mac_req_t;

	typedef struct packed {
		logic       valid;
		logic       dmode;
		logic [1:0] comp;
	} mac_rsp_t;

	typedef struct packed {
		logic [1:0] ia;
		logic [1:0] ib;
		logic       neg;
	} term_sel_t;

	// Hamilton product a*b, components (i, j, k, real)
	function automatic term_sel_t ham_sel(input logic [1:0] comp, input logic [1:0] term);
		term_sel_t s;
		unique case ({comp, term})
			4'h0: s = '{2'd3, 2'd0, 1'b0};
			4'h1: s = '{2'd0, 2'd3, 1'b0};
			4'h2: s = '{2'd1, 2'd2, 1'b0};
			4'h3: s = '{2'd2, 2'd1, 1'b1};
			4'h4: s = '{2'd3, 2'd1, 1'b0};
			4'h5: s = '{2'd0, 2'd2, 1'b1};
			4'h6: s = '{2'd1, 2'd3, 1'b0};
			4'h7: s = '{2'd2, 2'd0, 1'b0};
			4'h8: s = '{2'd3, 2'd2, 1'b0};
			4'h9: s = '{2'd0, 2'd1, 1'b0};
			4'hA: s = '{2'd1, 2'd0, 1'b1};
			4'hB: s = '{2'd2, 2'd3, 1'b0};
			4'hC: s = '{2'd3, 2'd3, 1'b0};
			4'hD: s = '{2'd0, 2'd0, 1'b1};
			4'hE: s = '{2'd1, 2'd1, 1'b1};
			4'hF: s = '{2'd2, 2'd2, 1'b1};
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// File: src/qeda_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qeda_ram: simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module qeda_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/qeda_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qeda_mac: shared multiply, round and accumulate unit
// One 33x33 multiplier, registered, then a rounding adder that either sums
// four terms of a Hamilton product component or yields a halved weight term.
// ----------------------------------------------------------------------------
module qeda_mac import qeda_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire mac_req_t                    req,
	input  wire logic signed [32:0]          op_a,
	input  wire logic signed [32:0]          op_b,
	output mac_rsp_t                         rsp,
	output logic signed [31:0]               ham,
	output logic signed [65-FRAC_BITS:0]     delta
);

	localparam int PW = 66;
	localparam int TW = PW - FRAC_BITS;
	localparam int SW = TW + 2;
	localparam logic signed [PW-1:0] RND_H = PW'(1) << (FRAC_BITS - 1);
	localparam logic signed [PW-1:0] RND_D = PW'(1) << FRAC_BITS;
	localparam logic signed [SW-1:0] S32_MAXV = SW'(33'sd2147483647);
	localparam logic signed [SW-1:0] S32_MINV = SW'(-33'sd2147483648);

	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_s1;
	mac_req_t             req_s1;
	logic signed [PW-1:0] sh_h, sh_d;
	logic signed [SW-1:0] term, base, sum_nx, sum_q;
	logic signed [31:0]   sat_v;

	assign prod = op_a * op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
	end

	always_comb begin
		sh_h   = (prod_s1 + RND_H) >>> FRAC_BITS;
		sh_d   = (prod_s1 + RND_D) >>> (FRAC_BITS + 1);
		term   = SW'($signed(sh_h[TW-1:0]));
		base   = req_s1.first ? '0 : sum_q;
		sum_nx = req_s1.neg ? base - term : base + term;
		if (sum_nx > S32_MAXV)
			sat_v = 32'sh7fff_ffff;
		else if (sum_nx < S32_MINV)
			sat_v = 32'sh8000_0000;
		else
			sat_v = sum_nx[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp <= '0;
		end else begin
			rsp.valid <= req_s1.valid & req_s1.last;
			rsp.dmode <= req_s1.dmode;
			rsp.comp  <= req_s1.comp;
		end
	end

	always_ff @(posedge clk) begin
		if (req_s1.valid) begin
			sum_q <= sum_nx;
			ham   <= sat_v;
			delta <= sh_d[TW-1:0];
		end
	end

endmodule
`default_nettype wire

// File: src/qeda_div6.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qeda_div6: four-lane divider by six
// Seven quotient bits per lane per cycle; each step divides
// the partial remainder by reciprocal multiplication.
// ----------------------------------------------------------------------------
module qeda_div6 import qeda_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIV_W-1:0]  dvd [4],
	output logic                   done,
	output logic [DIV_W-1:0]       quo [4]
);

	localparam int YW  = DIV_R + 3;
	localparam int PRW = YW + 10;

	logic [DIV_CW-1:0] cnt_q;
	logic              done_q;
	logic [DIV_W-1:0]  dvd_q [4];
	logic [2:0]        rem_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CW'(1));
			if (start)
				cnt_q <= DIV_CW'(DIV_STEPS);
			else if (cnt_q != '0)
				cnt_q <= cnt_q - DIV_CW'(1);
		end
	end

	for (genvar n = 0; n < 4; n++) begin : g_lane
		logic [YW-1:0]    y;
		logic [PRW-1:0]   pr;
		logic [DIV_R-1:0] qd;
		logic [YW-1:0]    qk;
		// partial dividend stays below 6 * 2^DIV_R
		assign y  = {rem_q[n], dvd_q[n][DIV_W-1 -: DIV_R]};
		assign pr = PRW'(y) * PRW'(DIV_RECIP);
		assign qd = pr[DIV_RSH +: DIV_R];
		assign qk = YW'(qd) * YW'(DIV_K);

		always_ff @(posedge clk) begin
			if (start) begin
				dvd_q[n] <= dvd[n];
				rem_q[n] <= '0;
			end else if (cnt_q != '0) begin
				// quotient digits shift in from the bottom as dividend digits leave
				dvd_q[n] <= {dvd_q[n][DIV_W-DIV_R-1:0], qd};
				rem_q[n] <= 3'(y - qk);
			end
		end

		assign quo[n] = dvd_q[n];
	end

	assign done = done_q;

endmodule
`default_nettype wire

// File: src/quaternion_edge_divergence_accumulator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_edge_divergence_accumulator: per-vertex quaternion accumulator
// Holds vertex positions, lambda quaternions and 48-bit accumulators and
// applies spin-transformation edge terms through one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with cmd, vertex indices and payload.
//   A load writes position and lambda and clears the accumulator.
//   An edge occupies the block through six Hamilton products of 16 terms
//   each on the shared multiplier, each followed by a pipeline drain, a
//   divide by six (five steps of seven quotient bits), four weight
//   multiplies and a read-modify-write of the two accumulators. A read
//   returns one result on out_valid/out_stall; loads, edges and unused
//   codes return nothing.
//   in_stall is high while any request is in progress, one at a time.
//   After reset a clearing pass zeroes the accumulator memory, with
//   in_stall held high. A stalled result holds its output register; a
//   read finding the output still occupied waits for it.
// ----------------------------------------------------------------------------
module quaternion_edge_divergence_accumulator import qeda_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         cmd,
	input  wire logic [9:0]         vert_a,
	input  wire logic [9:0]         vert_b,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	input  wire logic signed [31:0] lam_i,
	input  wire logic signed [31:0] lam_j,
	input  wire logic signed [31:0] lam_k,
	input  wire logic signed [31:0] lam_real,
	input  wire logic signed [31:0] cot_weight,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [47:0]      sum_i,
	output logic signed [47:0]      sum_j,
	output logic signed [47:0]      sum_k,
	output logic signed [47:0]      sum_real
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int DW = 66 - FRAC_BITS;
	localparam int UW = ((DW > 48) ? DW : 48) + 1;
	localparam logic signed [UW-1:0] S48_MAXV = UW'(49'sd140737488355327);
	localparam logic signed [UW-1:0] S48_MINV = UW'(-49'sd140737488355328);
	localparam logic signed [35:0]   DIV_BIAS = 36'sd12884901891;

	state_t state_q, state_d;
	prod_t  p_q;
	logic [AW-1:0] cnt_q, a_q, b_q;
	logic [3:0]    k_q;
	logic signed [31:0] w_q;
	logic          rd_oor_q;
	logic signed [31:0] pa_q [3];
	logic signed [31:0] l1_q [4];
	logic signed [31:0] l2_q [4];
	logic signed [31:0] e_q  [4];
	logic signed [31:0] t_q  [4];
	logic signed [31:0] et_q [4];
	logic signed [34:0] num_q [4];
	logic signed [DW-1:0] delta_q [4];
	logic               out_valid_q;
	logic signed [47:0] sum_q [4];

	logic accept, va_ok, vb_ok;
	logic [AW-1:0] lo_addr, hi_addr;
	logic          vs_re, load_we, acc_we, acc_re, div_start, out_load;
	logic [AW-1:0] vs_raddr, acc_waddr, acc_raddr;
	logic [191:0]  acc_wdata;
	logic [95:0]   pos_rdata;
	logic [127:0]  lam_rdata;
	logic [191:0]  acc_rdata;

	mac_req_t           mreq;
	mac_rsp_t           mrsp;
	term_sel_t          sel;
	logic signed [31:0] src_a, src_b;
	logic               conj_a;
	logic signed [32:0] op_a, op_b;
	logic signed [31:0] mac_ham;
	logic signed [DW-1:0] mac_delta;

	logic [DIV_W-1:0] div_dvd [4];
	logic [DIV_W-1:0] div_quo [4];
	logic             div_done;

	assign accept  = in_valid && !in_stall;
	assign va_ok   = int'(vert_a) < MAX_VERTICES;
	assign vb_ok   = int'(vert_b) < MAX_VERTICES;
	assign lo_addr = (vert_a < vert_b) ? AW'(vert_a) : AW'(vert_b);
	assign hi_addr = (vert_a < vert_b) ? AW'(vert_b) : AW'(vert_a);

	qeda_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk, .we(load_we), .waddr(AW'(vert_a)), .wdata({pos_z, pos_y, pos_x}),
		.re(vs_re), .raddr(vs_raddr), .rdata(pos_rdata)
	);

	qeda_ram #(.WIDTH(128), .DEPTH(MAX_VERTICES)) u_lam_ram (
		.clk, .we(load_we), .waddr(AW'(vert_a)),
		.wdata({lam_real, lam_k, lam_j, lam_i}),
		.re(vs_re), .raddr(vs_raddr), .rdata(lam_rdata)
	);

	qeda_ram #(.WIDTH(192), .DEPTH(MAX_VERTICES)) u_acc_ram (
		.clk, .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
	);

	qeda_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk, .arst_n, .req(mreq), .op_a, .op_b, .rsp(mrsp), .ham(mac_ham),
		.delta(mac_delta)
	);

	qeda_div6 u_div (
		.clk, .arst_n, .start(div_start), .dvd(div_dvd), .done(div_done), .quo(div_quo)
	);

	// biased so the dividend is never negative; the bias comes off after
	for (genvar n = 0; n < 4; n++) begin : g_dvd
		logic signed [35:0] biased;
		assign biased     = 36'(num_q[n]) + DIV_BIAS;
		assign div_dvd[n] = biased[DIV_W-1:0];
	end

	// operand selection for the shared multiplier
	always_comb begin
		sel    = ham_sel(k_q[3:2], k_q[1:0]);
		src_a  = t_q[sel.ia];
		src_b  = l2_q[sel.ib];
		conj_a = 1'b0;
		unique case (p_q) inside
			PROD_T1: begin
				src_a  = l1_q[sel.ia];
				src_b  = e_q[sel.ib];
				conj_a = 1'b1;
			end
			PROD_T2: begin
				src_a  = l2_q[sel.ia];
				src_b  = e_q[sel.ib];
				conj_a = 1'b1;
			end
			PROD_A, PROD_C: src_b = l1_q[sel.ib];
			default: ;
		endcase
		op_a = {src_a[31], src_a};
		op_b = {src_b[31], src_b};
		if (conj_a && sel.ia != 2'd3)
			op_a = -op_a;
		mreq = '0;
		if (state_q == ST_MUL) begin
			mreq = '{1'b1, k_q[1:0] == 2'd0, k_q[1:0] == 2'd3, sel.neg, 1'b0, k_q[3:2]};
		end else if (state_q == ST_DMUL) begin
			op_a = {et_q[k_q[1:0]][31], et_q[k_q[1:0]]};
			op_b = {w_q[31], w_q};
			mreq = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, k_q[1:0]};
		end
	end

	// accumulator update with 48-bit saturation
	always_comb begin
		logic signed [UW-1:0] upd;
		logic signed [47:0]   old;
		acc_wdata = '0;
		for (int n = 0; n < 4; n++) begin
			old = acc_rdata[48*n +: 48];
			if (state_q == ST_ACC_WB)
				upd = UW'(old) + UW'(delta_q[n]);
			else
				upd = UW'(old) - UW'(delta_q[n]);
			if (upd > S48_MAXV)
				upd = S48_MAXV;
			else if (upd < S48_MINV)
				upd = S48_MINV;
			if (state_q == ST_ACC_WA || state_q == ST_ACC_WB)
				acc_wdata[48*n +: 48] = upd[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		vs_re     = 1'b0;
		vs_raddr  = b_q;
		load_we   = 1'b0;
		acc_we    = 1'b0;
		acc_waddr = a_q;
		acc_re    = 1'b0;
		acc_raddr = a_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				acc_we    = 1'b1;
				acc_waddr = cnt_q;
				if (cnt_q == AW'(MAX_VERTICES - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (cmd_t'(cmd))
						CMD_LOAD: begin
							load_we   = va_ok;
							acc_we    = va_ok;
							acc_waddr = AW'(vert_a);
						end
						CMD_EDGE: begin
							if (va_ok && vb_ok) begin
								vs_re    = 1'b1;
								vs_raddr = lo_addr;
								state_d  = ST_RDB;
							end
						end
						CMD_READ: begin
							acc_re    = 1'b1;
							acc_raddr = AW'(vert_a);
							state_d   = ST_RD_DATA;
						end
						default: ;
					endcase
				end
			end
			ST_RDB: begin
				vs_re   = 1'b1;
				state_d = ST_CAPB;
			end
			ST_CAPB: state_d = ST_MUL;
			ST_MUL: begin
				if (k_q == 4'd15)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (k_q[0])
					state_d = (p_q == PROD_D) ? ST_DIVGO : ST_MUL;
			end
			ST_DIVGO: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done)
					state_d = ST_DMUL;
			end
			ST_DMUL: begin
				if (k_q[1:0] == 2'd3)
					state_d = ST_DRAIN2;
			end
			ST_DRAIN2: begin
				if (k_q[0])
					state_d = ST_ACC_RA;
			end
			ST_ACC_RA: begin
				acc_re  = 1'b1;
				state_d = ST_ACC_WA;
			end
			ST_ACC_WA: begin
				acc_we  = 1'b1;
				state_d = ST_ACC_RB;
			end
			ST_ACC_RB: begin
				acc_re    = 1'b1;
				acc_raddr = b_q;
				state_d   = ST_ACC_WB;
			end
			ST_ACC_WB: begin
				acc_we    = 1'b1;
				acc_waddr = b_q;
				state_d   = ST_IDLE;
			end
			ST_RD_DATA: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			k_q         <= '0;
			p_q         <= PROD_T1;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLR)
				cnt_q <= cnt_q + AW'(1);
			k_q <= (state_d != state_q) ? 4'd0 : k_q + 4'd1;
			if (accept)
				p_q <= PROD_T1;
			else if (state_q == ST_DRAIN && k_q[0] && p_q != PROD_D)
				p_q <= prod_t'(p_q + 3'd1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q      <= lo_addr;
			b_q      <= hi_addr;
			w_q      <= cot_weight;
			rd_oor_q <= !va_ok;
			for (int n = 0; n < 4; n++)
				num_q[n] <= '0;
		end
		if (state_q == ST_RDB) begin
			for (int n = 0; n < 3; n++)
				pa_q[n] <= pos_rdata[32*n +: 32];
			for (int n = 0; n < 4; n++)
				l1_q[n] <= lam_rdata[32*n +: 32];
		end
		if (state_q == ST_CAPB) begin
			for (int n = 0; n < 4; n++)
				l2_q[n] <= lam_rdata[32*n +: 32];
			for (int n = 0; n < 3; n++) begin
				logic signed [32:0] d;
				d = 33'(pa_q[n]) - 33'($signed(pos_rdata[32*n +: 32]));
				if (d > 33'sd2147483647)
					e_q[n] <= 32'sh7fff_ffff;
				else if (d < -33'sd2147483648)
					e_q[n] <= 32'sh8000_0000;
				else
					e_q[n] <= d[31:0];
			end
			e_q[3] <= '0;
		end
		if (mrsp.valid) begin
			if (mrsp.dmode) begin
				delta_q[mrsp.comp] <= mac_delta;
			end else begin
				case (p_q) inside
					PROD_T1, PROD_T2: t_q[mrsp.comp] <= mac_ham;
					PROD_A, PROD_D:
						num_q[mrsp.comp] <= num_q[mrsp.comp]
							+ 35'($signed({mac_ham, 1'b0}));
					default:
						num_q[mrsp.comp] <= num_q[mrsp.comp] + 35'(mac_ham);
				endcase
			end
		end
		if (div_done) begin
			// quotient carries a bias of 2^31
			for (int n = 0; n < 4; n++)
				et_q[n] <= {~div_quo[n][31], div_quo[n][30:0]};
		end
		if (out_load) begin
			for (int n = 0; n < 4; n++)
				sum_q[n] <= rd_oor_q ? '0 : acc_rdata[48*n +: 48];
		end
	end

	assign out_valid = out_valid_q;
	assign sum_i     = sum_q[0];
	assign sum_j     = sum_q[1];
	assign sum_k     = sum_q[2];
	assign sum_real  = sum_q[3];

	a_edge_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> a_q <= b_q)
		else $error("edge ends not ordered");

	a_mac_rsp_window: assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.valid |-> (state_q == ST_MUL || state_q == ST_DRAIN ||
			state_q == ST_DMUL || state_q == ST_DRAIN2))
		else $error("multiplier result outside compute phase");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RD_DATA))
		else $error("result raised without a read");

endmodule
`default_nettype wire

// File: verif/tb_quaternion_edge_divergence_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quaternion_edge_divergence_accumulator: self-checking bench
// Drives load, edge, read and unused requests with random idling on both
// channels, predicts every read result with a fixed-point quaternion model
// kept in the bench and checks each returned sum field by field.
// ----------------------------------------------------------------------------
module tb_quaternion_edge_divergence_accumulator import qeda_pkg::*; ();

	localparam int FRAC   = FRAC_BITS_DEF;
	localparam int NVERT  = MAX_VERTICES_DEF;
	localparam int STUCK_LIMIT = 20000;

	typedef longint quat_t [4];

	typedef struct {
		cmd_t               op;
		logic [9:0]         va;
		logic [9:0]         vb;
		logic signed [31:0] p [3];
		logic signed [31:0] l [4];
		logic signed [31:0] w;
	} request_t;

	typedef struct packed {
		logic [47:0] si;
		logic [47:0] sj;
		logic [47:0] sk;
		logic [47:0] sr;
	} sums_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [9:0] vert_a = '0, vert_b = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] lam_i = '0, lam_j = '0, lam_k = '0, lam_real = '0;
	logic signed [31:0] cot_weight = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [47:0] sum_i, sum_j, sum_k, sum_real;

	always #5 clk = ~clk;

	quaternion_edge_divergence_accumulator uut (.*);

	// bench copy of the vertex stores
	int     pos_mem [NVERT][3];
	int     lam_mem [NVERT][4];
	longint acc_mem [NVERT][4];
	int     loaded_q [$];
	bit     is_loaded [NVERT];

	sums_t  pending_sums [$];
	int     errors = 0;
	int     n_loads = 0, n_edges = 0, n_reads = 0, n_nops = 0, n_results = 0;
	bit     steady = 1'b0;   // no idling on either side
	int     quiet_cycles = 0;

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint sat32(longint v);
		return sat(v, -64'sd2147483648, 64'sd2147483647);
	endfunction

	function automatic longint sat48(longint v);
		return sat(v, -64'sd140737488355328, 64'sd140737488355327);
	endfunction

	function automatic longint fx_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic void hamilton(input quat_t a, input quat_t b, output quat_t r);
		r[0] = sat32(fx_mul(a[3], b[0]) + fx_mul(a[0], b[3]) + fx_mul(a[1], b[2])
			- fx_mul(a[2], b[1]));
		r[1] = sat32(fx_mul(a[3], b[1]) - fx_mul(a[0], b[2]) + fx_mul(a[1], b[3])
			+ fx_mul(a[2], b[0]));
		r[2] = sat32(fx_mul(a[3], b[2]) + fx_mul(a[0], b[1]) - fx_mul(a[1], b[0])
			+ fx_mul(a[2], b[3]));
		r[3] = sat32(fx_mul(a[3], b[3]) - fx_mul(a[0], b[0]) - fx_mul(a[1], b[1])
			- fx_mul(a[2], b[2]));
	endfunction

	function automatic void sandwich(input quat_t lc, input quat_t e, input quat_t l,
			output quat_t r);
		quat_t t;
		hamilton(lc, e, t);
		hamilton(t, l, r);
	endfunction

	function automatic void apply_edge(int a, int b, longint w);
		quat_t l1, l1c, l2, l2c, e, qa, qb, qc, qd;
		longint num, q, d;
		int tmp;
		if (a > b) begin
			tmp = a; a = b; b = tmp;
		end
		for (int n = 0; n < 3; n++)
			e[n] = sat32(longint'(pos_mem[a][n]) - longint'(pos_mem[b][n]));
		e[3] = 0;
		for (int n = 0; n < 4; n++) begin
			l1[n] = lam_mem[a][n];
			l2[n] = lam_mem[b][n];
			l1c[n] = n == 3 ? l1[n] : -l1[n];
			l2c[n] = n == 3 ? l2[n] : -l2[n];
		end
		sandwich(l1c, e, l1, qa);
		sandwich(l1c, e, l2, qb);
		sandwich(l2c, e, l1, qc);
		sandwich(l2c, e, l2, qd);
		for (int n = 0; n < 4; n++) begin
			num = 2 * (qa[n] + qd[n]) + qb[n] + qc[n] + 3;
			q = num / 6;
			if (num % 6 != 0 && num < 0)
				q--;
			q = sat32(q);
			d = (q * w + (64'sd1 <<< FRAC)) >>> (FRAC + 1);
			acc_mem[a][n] = sat48(acc_mem[a][n] - d);
			acc_mem[b][n] = sat48(acc_mem[b][n] + d);
		end
	endfunction

	function automatic void predict(request_t r);
		sums_t s;
		case (r.op)
			CMD_LOAD: begin
				for (int n = 0; n < 3; n++) pos_mem[r.va][n] = r.p[n];
				for (int n = 0; n < 4; n++) begin
					lam_mem[r.va][n] = r.l[n];
					acc_mem[r.va][n] = 0;
				end
				if (!is_loaded[r.va]) begin
					is_loaded[r.va] = 1'b1;
					loaded_q.push_back(r.va);
				end
				n_loads++;
			end
			CMD_EDGE: begin
				apply_edge(r.va, r.vb, r.w);
				n_edges++;
			end
			CMD_READ: begin
				s.si = acc_mem[r.va][0][47:0];
				s.sj = acc_mem[r.va][1][47:0];
				s.sk = acc_mem[r.va][2][47:0];
				s.sr = acc_mem[r.va][3][47:0];
				pending_sums.push_back(s);
				n_reads++;
			end
			default: n_nops++;
		endcase
	endfunction

	function automatic bit idle_now();
		return !steady && $urandom_range(0, 99) < 18;
	endfunction

	task automatic send(request_t r);
		bit stalled;
		if (idle_now()) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (idle_now());
		end
		cmd <= r.op;
		vert_a <= r.va;
		vert_b <= r.vb;
		pos_x <= r.p[0]; pos_y <= r.p[1]; pos_z <= r.p[2];
		lam_i <= r.l[0]; lam_j <= r.l[1]; lam_k <= r.l[2]; lam_real <= r.l[3];
		cot_weight <= r.w;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		predict(r);
	endtask

	// Q16.16 value: full range, near unity, or an extreme
	function automatic logic signed [31:0] rand_fix();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 0;
					3: return 32'sh00010000;
					default: return -32'sh00010000;
				endcase
			end
			default: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh20000;
		endcase
	endfunction

	function automatic request_t make_load(int v);
		request_t r;
		r.op = CMD_LOAD;
		r.va = 10'(v);
		r.vb = 10'($urandom);
		for (int n = 0; n < 3; n++) r.p[n] = rand_fix();
		for (int n = 0; n < 4; n++) r.l[n] = rand_fix();
		r.w = $urandom;
		return r;
	endfunction

	function automatic request_t make_cmd(cmd_t op, int a, int b, logic signed [31:0] w);
		request_t r;
		r = make_load(a);
		r.op = op;
		r.vb = 10'(b);
		r.w = w;
		return r;
	endfunction

	function automatic int pick_loaded();
		return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
	endfunction

	task automatic test_reset_state();
		send(make_cmd(CMD_READ, 0, 0, 0));
		send(make_cmd(CMD_READ, NVERT - 1, 0, 0));
	endtask

	task automatic test_extremes();
		request_t r;
		r = make_load(0);
		r.p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
		r.l = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
		send(r);
		r = make_load(NVERT - 1);
		r.p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		r.l = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000};
		send(r);
		r = make_load(5);
		r.p = '{32'sh00010000, -32'sh00020000, 0};
		r.l = '{0, 0, 0, 32'sh00010000};
		send(r);
		send(make_cmd(CMD_EDGE, 0, NVERT - 1, 32'sh7fffffff));
		send(make_cmd(CMD_EDGE, NVERT - 1, 0, 32'sh80000000));
		send(make_cmd(CMD_EDGE, 5, 0, 32'sh00010000));
		send(make_cmd(CMD_EDGE, 0, 5, -32'sh00010000));
		send(make_cmd(CMD_EDGE, 5, NVERT - 1, 0));
		for (int k = 0; k < 3; k++)
			send(make_cmd(CMD_EDGE, 0, NVERT - 1, 32'sh7fffffff));
		send(make_cmd(CMD_READ, 0, 0, 0));
		send(make_cmd(CMD_READ, NVERT - 1, 0, 0));
		send(make_cmd(CMD_READ, 5, 0, 0));
	endtask

	task automatic test_special_cases();
		// equal ends leave both accumulators alone
		send(make_cmd(CMD_EDGE, 5, 5, 32'sh7fffffff));
		send(make_cmd(CMD_READ, 5, 0, 0));
		// unused code carries a random payload and must do nothing
		send(make_cmd(CMD_NOP, $urandom, $urandom, $urandom));
		send(make_cmd(CMD_NOP, 0, 0, 0));
		// reload clears the accumulator
		send(make_load(0));
		send(make_cmd(CMD_READ, 0, 0, 0));
	endtask

	task automatic test_random(int count);
		request_t r;
		int sel;
		for (int k = 0; k < count; k++) begin
			steady = k >= count / 3 && k < count / 3 + 300;
			sel = $urandom_range(0, 99);
			if (sel < 20)
				r = make_load($urandom_range(0, 5) == 0 ? $urandom_range(0, NVERT - 1)
					: $urandom_range(0, 15));
			else if (sel < 60)
				r = make_cmd(CMD_EDGE, pick_loaded(), pick_loaded(), rand_fix());
			else if (sel < 95)
				r = make_cmd(CMD_READ, $urandom_range(0, 3) == 0
					? $urandom_range(0, NVERT - 1) : pick_loaded(), $urandom, $urandom);
			else
				r = make_cmd(CMD_NOP, $urandom, $urandom, $urandom);
			send(r);
		end
		steady = 1'b0;
	endtask

	// result side: stall at random and check each accepted result
	always @(posedge clk)
		out_stall <= idle_now();

	always @(negedge clk) begin
		sums_t s;
		bit    moved;
		moved = arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall));
		quiet_cycles <= moved ? 0 : quiet_cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (pending_sums.size() == 0) begin
				$error("unexpected result: sum_i=%0h", sum_i);
				errors++;
			end else begin
				s = pending_sums.pop_front();
				if (sum_i !== s.si) begin
					$error("sum_i expected %0h actual %0h", s.si, sum_i); errors++;
				end
				if (sum_j !== s.sj) begin
					$error("sum_j expected %0h actual %0h", s.sj, sum_j); errors++;
				end
				if (sum_k !== s.sk) begin
					$error("sum_k expected %0h actual %0h", s.sk, sum_k); errors++;
				end
				if (sum_real !== s.sr) begin
					$error("sum_real expected %0h actual %0h", s.sr, sum_real); errors++;
				end
			end
		end
	end

	always @(posedge clk)
		if (quiet_cycles >= STUCK_LIMIT) begin
			$display("watchdog: no request or result for %0d cycles", STUCK_LIMIT);
			$display("Verification failed");
			$finish;
		end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_extremes();
		test_special_cases();
		test_random(1950);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (pending_sums.size() != 0) begin
			$error("%0d results never arrived", pending_sums.size());
			errors++;
		end
		$display("covered %0d loads, %0d edges, %0d reads, %0d unused codes",
			n_loads, n_edges, n_reads, n_nops);
		$display("%0d results checked, %0d mismatches", n_results, errors);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
